// ===== src/lulf_pkg.sv =====
package lulf_pkg;

   // grid geometry
   localparam int MAX_SIDE = 1024;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int LEN_W    = COORD_W + 1;
   localparam int PIX_W    = 8;
   localparam int DIR_W    = 2;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int GRID_W     = 11;
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(MAX_SIDE);

   typedef enum logic [DIR_W-1:0] {
      DIR_VERTICAL   = 2'd0,
      DIR_UP_RIGHT   = 2'd1,
      DIR_HORIZONTAL = 2'd2,
      DIR_DOWN_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [0:0] {
      REG_GRID_SIZE = 1'b0
   } reg_index_type;

   // one line buffer entry: cell value and its three non-horizontal runs
   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [LEN_W-1:0] vrun;
      logic [LEN_W-1:0] drun;
      logic [LEN_W-1:0] urun;
   } entry_type;

   typedef struct packed {
      logic [PIX_W-1:0]   value;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [LEN_W-1:0]   len;
      dir_type            dir;
   } line_type;

   // a pixel in flight with its position flags
   typedef struct packed {
      logic [PIX_W-1:0]   value;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               first_col;
      logic               first_row;
      logic               last_col;
      logic               last_row;
   } cell_type;

   typedef struct packed {
      logic [LEN_W-1:0] size;
      logic             restart;
   } csr_ctrl_type;

endpackage

// ===== src/longest_uniform_line_finder.sv =====
// Longest uniform line finder. Pixels of a square grid arrive in raster order, one per
// transfer on the req_ channel; on the transfer of the grid's last pixel the block
// delivers one result on the rsp_ channel: value, start column and row, length and
// direction (0 vertical, 1 up-right, 2 horizontal, 3 down-right) of the longest run of
// equal nonzero cells, the earliest one winning a tie, or all zeros for an empty grid.
// The block takes one pixel per clock while req_stall is low. The result is registered
// when the held last pixel retires; req_stall rises only while a finished result
// waits and the next grid's last pixel is already held. State per column lives in one
// line buffer of MAX_SIDE entries with two synchronous read ports and one write port; it
// needs no clearing pass after reset. Writing grid_size (offset 0) restarts the frame.
module longest_uniform_line_finder (
   input  logic                            clock,
   input  logic                            reset,
   // pixel channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lulf_pkg::PIX_W-1:0]      req_pixel_value,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lulf_pkg::PIX_W-1:0]      rsp_line_value,
   output logic [lulf_pkg::COORD_W-1:0]    rsp_start_x,
   output logic [lulf_pkg::COORD_W-1:0]    rsp_start_y,
   output logic [lulf_pkg::LEN_W-1:0]      rsp_line_length,
   output logic [lulf_pkg::DIR_W-1:0]      rsp_direction,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lulf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lulf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lulf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lulf_pkg::*;

   csr_ctrl_type ctrl;

   // scan position of the next pixel
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] col_in;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] row_in;

   // pixel whose line buffer entries are being read
   logic               s1_valid_ff;
   logic               s1_valid_in;
   cell_type           s1_cell_ff;
   cell_type           cell_new;

   // horizontal run, previous pixel, left-up entry and best line so far
   logic [LEN_W-1:0]   hrun_ff;
   logic [LEN_W-1:0]   hrun_in;
   logic [PIX_W-1:0]   prev_ff;
   logic [PIX_W-1:0]   prev_in;
   entry_type          diag_ff;
   line_type           best_ff;
   line_type           best_in;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   line_type           rsp_line_ff;

   logic               accept;
   logic               commit;
   logic               frame_end;
   entry_type          up;
   entry_type          right_up;
   entry_type          fresh;
   logic [LEN_W-1:0]   hrun_cell;
   line_type           best_cell;

   lulf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .ctrl    (ctrl)
   );

   // the held pixel may only retire when its result has somewhere to go
   assign req_stall = s1_valid_ff && s1_cell_ff.last_col && s1_cell_ff.last_row
                      && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign commit    = s1_valid_ff && !req_stall;
   assign frame_end = commit && s1_cell_ff.last_col && s1_cell_ff.last_row;

   // entries above and above-right of the incoming pixel are read as it transfers
   lulf_line_ram u_line_ram (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (col_ff),
      .rd_addr_b (col_ff + COORD_W'(1)),
      .wr_en     (commit),
      .wr_addr   (s1_cell_ff.x),
      .wr_data   (fresh),
      .rd_data_a (up),
      .rd_data_b (right_up)
   );

   lulf_cell_update u_cell_update (
      .site       (s1_cell_ff),
      .up         (up),
      .right_up   (right_up),
      .left_up    (diag_ff),
      .hrun_prev  (hrun_ff),
      .prev_pixel (prev_ff),
      .best_cur   (best_ff),
      .fresh      (fresh),
      .hrun       (hrun_cell),
      .best_next  (best_cell)
   );

   // position flags for the incoming pixel
   always_comb begin
      cell_new.value     = req_pixel_value;
      cell_new.x         = col_ff;
      cell_new.y         = row_ff;
      cell_new.first_col = (col_ff == '0);
      cell_new.first_row = (row_ff == '0);
      cell_new.last_col  = ({1'b0, col_ff} + LEN_W'(1)) >= ctrl.size;
      cell_new.last_row  = ({1'b0, row_ff} + LEN_W'(1)) >= ctrl.size;
   end

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (cell_new.last_col) begin
            col_in = '0;
            row_in = cell_new.last_row ? '0 : row_ff + COORD_W'(1);
         end else begin
            col_in = col_ff + COORD_W'(1);
         end
      end
   end

   // run state moves on when a pixel retires; row end and frame end clear it
   always_comb begin
      hrun_in = hrun_ff;
      prev_in = prev_ff;
      best_in = best_ff;
      if (ctrl.restart) begin
         hrun_in = '0;
         prev_in = '0;
         best_in = '0;
      end else if (commit) begin
         hrun_in = s1_cell_ff.last_col ? '0 : hrun_cell;
         prev_in = s1_cell_ff.last_col ? '0 : s1_cell_ff.value;
         best_in = frame_end ? '0 : best_cell;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         hrun_ff      <= '0;
         prev_ff      <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         hrun_ff      <= hrun_in;
         prev_ff      <= prev_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff <= cell_new;
      end
      if (commit) begin
         diag_ff <= up;
      end
      if (frame_end) begin
         rsp_line_ff <= best_cell;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_value  = rsp_line_ff.value;
   assign rsp_start_x     = rsp_line_ff.sx;
   assign rsp_start_y     = rsp_line_ff.sy;
   assign rsp_line_length = rsp_line_ff.len;
   assign rsp_direction   = rsp_line_ff.dir;

`ifndef SYNTHESIS
   // a retiring last pixel always leaves a result behind
   a_frame_end_result: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> rsp_valid_ff)
      else $error("frame end gave no result");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !frame_end)
      else $error("result overwritten while stalled");

   // the scan position (column and row) stays inside the grid
   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < ctrl.size) && ({1'b0, row_ff} < ctrl.size))
      else $error("scan position outside the grid");

   // no line can be longer than the grid side
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      best_ff.len <= ctrl.size)
      else $error("best line longer than grid side");
`endif

endmodule

// ===== src/lulf_line_ram.sv =====
module lulf_line_ram (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [lulf_pkg::COORD_W-1:0] rd_addr_a,
   input  logic [lulf_pkg::COORD_W-1:0] rd_addr_b,
   input  logic                        wr_en,
   input  logic [lulf_pkg::COORD_W-1:0] wr_addr,
   input  lulf_pkg::entry_type          wr_data,
   output lulf_pkg::entry_type          rd_data_a,
   output lulf_pkg::entry_type          rd_data_b
);
   import lulf_pkg::*;

   entry_type mem [MAX_SIDE];

   entry_type q_a_ff;
   entry_type q_b_ff;
   entry_type fwd_ff;
   logic      byp_a_ff;
   logic      byp_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_a_ff   <= mem[rd_addr_a];
         q_b_ff   <= mem[rd_addr_b];
         // same-edge write to a read address: hand over the new entry
         byp_a_ff <= wr_en && (wr_addr == rd_addr_a);
         byp_b_ff <= wr_en && (wr_addr == rd_addr_b);
         fwd_ff   <= wr_data;
      end
   end

   assign rd_data_a = byp_a_ff ? fwd_ff : q_a_ff;
   assign rd_data_b = byp_b_ff ? fwd_ff : q_b_ff;

endmodule

// ===== src/lulf_cell_update.sv =====
module lulf_cell_update (
   input  lulf_pkg::cell_type          site,
   input  lulf_pkg::entry_type         up,
   input  lulf_pkg::entry_type         right_up,
   input  lulf_pkg::entry_type         left_up,
   input  logic [lulf_pkg::LEN_W-1:0]  hrun_prev,
   input  logic [lulf_pkg::PIX_W-1:0]  prev_pixel,
   input  lulf_pkg::line_type          best_cur,
   output lulf_pkg::entry_type         fresh,
   output logic [lulf_pkg::LEN_W-1:0]  hrun,
   output lulf_pkg::line_type          best_next
);
   import lulf_pkg::*;

   localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

   logic             nz;
   logic [LEN_W-1:0] vrun;
   logic [LEN_W-1:0] urun;
   logic [LEN_W-1:0] hlen;
   logic [LEN_W-1:0] drun;
   logic [LEN_W-1:0] x_ext;
   logic [LEN_W-1:0] y_ext;
   line_type         cand_v;
   line_type         cand_u;
   line_type         cand_h;
   line_type         cand_d;
   line_type         pick_a;
   line_type         pick_b;
   line_type         pick;

   always_comb begin
      nz    = (site.value != '0);
      x_ext = {1'b0, site.x};
      y_ext = {1'b0, site.y};

      vrun = (!site.first_row && up.value == site.value) ? up.vrun + ONE : ONE;
      urun = (!site.first_row && !site.last_col && right_up.value == site.value)
             ? right_up.urun + ONE : ONE;
      hlen = (!site.first_col && prev_pixel == site.value) ? hrun_prev + ONE : ONE;
      drun = (!site.first_row && !site.first_col && left_up.value == site.value)
             ? left_up.drun + ONE : ONE;

      if (!nz) begin
         vrun = '0;
         urun = '0;
         hlen = '0;
         drun = '0;
      end

      fresh.value = site.value;
      fresh.vrun  = vrun;
      fresh.drun  = drun;
      fresh.urun  = urun;
      hrun        = hlen;

      cand_v = '{value: site.value, sx: site.x,
                 sy: COORD_W'(y_ext + ONE - vrun), len: vrun, dir: DIR_VERTICAL};
      cand_u = '{value: site.value, sx: site.x, sy: site.y, len: urun, dir: DIR_UP_RIGHT};
      cand_h = '{value: site.value, sx: COORD_W'(x_ext + ONE - hlen), sy: site.y,
                 len: hlen, dir: DIR_HORIZONTAL};
      cand_d = '{value: site.value, sx: COORD_W'(x_ext + ONE - drun),
                 sy: COORD_W'(y_ext + ONE - drun), len: drun, dir: DIR_DOWN_RIGHT};

      // earlier direction wins a tie
      pick_a = (cand_u.len > cand_v.len) ? cand_u : cand_v;
      pick_b = (cand_d.len > cand_h.len) ? cand_d : cand_h;
      pick   = (pick_b.len > pick_a.len) ? pick_b : pick_a;

      best_next = (nz && pick.len > best_cur.len) ? pick : best_cur;
   end

endmodule

// ===== src/lulf_csr.sv =====
module lulf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lulf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lulf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lulf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output lulf_pkg::csr_ctrl_type          ctrl
);
   import lulf_pkg::*;

   logic [GRID_W-1:0] grid_ff;
   logic [GRID_W-1:0] grid_in;
   logic              wr_grid;
   reg_index_type     index;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign pready = 1'b1;

   always_comb begin
      wr_grid = 1'b0;
      prdata  = '0;
      unique case (index)
         REG_GRID_SIZE: begin
            wr_grid = psel && penable && pwrite;
            prdata  = CSR_DATA_W'(grid_ff);
         end
         default: begin
            wr_grid = 1'b0;
            prdata  = '0;
         end
      endcase
      grid_in = wr_grid ? pwdata[GRID_W-1:0] : grid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= GRID_RESET;
      end else begin
         grid_ff <= grid_in;
      end
   end

   // zero acts as one, oversize acts as the line buffer depth
   always_comb begin
      if (grid_ff == '0) begin
         ctrl.size = LEN_W'(1);
      end else if (int'(grid_ff) > MAX_SIDE) begin
         ctrl.size = LEN_W'(MAX_SIDE);
      end else begin
         ctrl.size = LEN_W'(grid_ff);
      end
      ctrl.restart = wr_grid;
   end

endmodule
